[rtl/cat_pkg.sv]
// cat_pkg: shared constants, types and row update functions for the capcode
// activity table. No dependencies; cat_ctrl, cat_dpath, the top level and cat_checker import it.
package cat_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W       = 5;
   localparam int WIDE_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [15:0] SAT16 = 16'hFFFF;
   localparam logic [7:0]  SAT8  = 8'hFF;

   typedef logic [2:0] cmd_type;
   localparam cmd_type CMD_RECORD  = 3'd0;
   localparam cmd_type CMD_READ    = 3'd1;
   localparam cmd_type CMD_BUSIEST = 3'd2;
   localparam cmd_type CMD_SORT    = 3'd3;
   localparam cmd_type CMD_TALLY   = 3'd4;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK   = 2'd0;
   localparam status_type ST_MISS = 2'd1;
   localparam status_type ST_FULL = 2'd2;

   typedef logic [2:0] role_type;
   localparam role_type ROLE_UNKNOWN  = 3'd0;
   localparam role_type ROLE_TONE     = 3'd1;
   localparam role_type ROLE_CALLBACK = 3'd2;
   localparam role_type ROLE_CLINICAL = 3'd3;
   localparam role_type ROLE_DISPATCH = 3'd4;
   localparam role_type ROLE_ROUTINE  = 3'd5;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_IDENTITY = 3'd0;
   localparam csr_idx_type CSR_LOCATION = 3'd1;
   localparam csr_idx_type CSR_CLINICAL = 3'd2;
   localparam csr_idx_type CSR_INCIDENT = 3'd3;
   localparam csr_idx_type CSR_TONE     = 3'd4;
   localparam csr_idx_type CSR_NUMERIC  = 3'd5;

   typedef struct packed {
      logic [15:0] identity_mask;
      logic [15:0] location_mask;
      logic [15:0] clinical_mask;
      logic [15:0] incident_mask;
      logic [1:0]  tone_kind;
      logic [1:0]  numeric_kind;
   } cfg_type;

   typedef struct packed {
      logic [20:0] key;
      logic [31:0] first_tick;
      logic [31:0] last_tick;
      logic [15:0] pages;
      logic [15:0] flags;
      logic [3:0]  kinds;
      logic [3:0]  grade;
      logic [7:0]  score;
      logic [31:0] category;
      role_type    role;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   typedef struct packed {
      status_type status;
      row_type    row;
   } res_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_REC_RD, S_REC_CHK, S_REC_NEW, S_READ_WAIT,
      S_BUS_RD, S_BUS_CHK, S_TAL_RD, S_TAL_CHK, S_SORT_I, S_SORT_KEY,
      S_SORT_J, S_SORT_CMP, S_FINISH
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LATCH, OP_RD_PTR, OP_PTR_INC, OP_REC_HIT, OP_REC_NEW,
      OP_REC_DROP, OP_RD_IDX, OP_READ_DONE, OP_MISS, OP_BUS_STEP, OP_BUS_DONE,
      OP_TAL_STEP, OP_TAL_DONE, OP_SORT_INIT, OP_SORT_KEY, OP_RD_JM1,
      OP_SORT_SHIFT, OP_SORT_PLACE, OP_SORT_DONE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      rsp_load;
      logic      req_ready;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    req_valid;
      logic    at_end;
      logic    hit;
      logic    full;
      logic    j_zero;
      logic    ahead;
      logic    in_range;
      logic    out_free;
   } sts_type;

   function automatic logic [7:0] byte_inc(logic [7:0] b);
      return (b != SAT8) ? b + 8'd1 : b;
   endfunction

   function automatic role_type infer_role(row_type r, cfg_type c);
      logic [3:0] tone;
      logic [3:0] num;
      logic [7:0] clin;
      logic [7:0] inc;
      tone = 4'b0001 << c.tone_kind;
      num  = 4'b0001 << c.numeric_kind;
      clin = r.category[7:0];
      inc  = r.category[15:8];
      if (r.pages == 16'd0) return ROLE_UNKNOWN;
      if (r.kinds == tone) return ROLE_TONE;
      if ((r.kinds & ~(tone | num)) == 4'd0) return ROLE_CALLBACK;
      if (clin != 8'd0 && clin >= inc) return ROLE_CLINICAL;
      if (inc != 8'd0) return ROLE_DISPATCH;
      return ROLE_ROUTINE;
   endfunction

   function automatic row_type rec_update(row_type r, logic [15:0] fl, logic [1:0] kind,
                                          logic [7:0] sc, logic [3:0] gr,
                                          logic [31:0] tick, cfg_type c);
      row_type u;
      u = r;
      if (u.pages != SAT16) u.pages = u.pages + 16'd1;
      u.last_tick = tick;
      u.flags     = u.flags | fl;
      u.kinds     = u.kinds | (4'b0001 << kind);
      if (sc > u.score) begin
         u.score = sc;
         u.grade = gr;
      end
      if ((fl & c.clinical_mask) != 16'd0) u.category[7:0]   = byte_inc(u.category[7:0]);
      if ((fl & c.incident_mask) != 16'd0) u.category[15:8]  = byte_inc(u.category[15:8]);
      if ((fl & c.identity_mask) != 16'd0) u.category[23:16] = byte_inc(u.category[23:16]);
      if ((fl & c.location_mask) != 16'd0) u.category[31:24] = byte_inc(u.category[31:24]);
      u.role = infer_role(u, c);
      return u;
   endfunction

endpackage

[rtl/cat_if.sv]
// cat_req_if / cat_rsp_if: valid/ready channels for request and response words.
// Depends on nothing.
interface cat_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [20:0] capcode;
   logic [1:0]  page_kind;
   logic [15:0] leak_flags;
   logic [7:0]  score;
   logic [3:0]  grade;
   logic [31:0] tick_ms;
   logic [4:0]  index;
   modport source(output valid, cmd, capcode, page_kind, leak_flags, score, grade,
                  tick_ms, index, input ready);
   modport sink(input valid, cmd, capcode, page_kind, leak_flags, score, grade,
                tick_ms, index, output ready);
endinterface

interface cat_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [20:0] entry_capcode;
   logic [15:0] page_total;
   logic [31:0] first_seen;
   logic [31:0] last_seen;
   logic [15:0] flags_seen;
   logic [7:0]  worst_score_out;
   logic [3:0]  worst_grade_out;
   logic [31:0] category_counts;
   logic [2:0]  role;
   logic [5:0]  occupancy;
   logic [15:0] overflow_count;
   modport source(output valid, status, entry_capcode, page_total, first_seen, last_seen,
                  flags_seen, worst_score_out, worst_grade_out, category_counts, role,
                  occupancy, overflow_count, input ready);
   modport sink(input valid, status, entry_capcode, page_total, first_seen, last_seen,
                flags_seen, worst_score_out, worst_grade_out, category_counts, role,
                occupancy, overflow_count, output ready);
endinterface

[rtl/cat_ram.sv]
// cat_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module cat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rdata_ff;
endmodule

[rtl/cat_ctrl.sv]
// cat_ctrl: sequencer for record, read, busiest, sort and tally commands.
// Depends on cat_pkg; drives cat_dpath through ctl_type, watches sts_type.
module cat_ctrl import cat_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  sts_type sts,
   output ctl_type ctl
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      ctl.op        = OP_NONE;
      ctl.rsp_load  = 1'b0;
      ctl.req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            ctl.req_ready = 1'b1;
            if (sts.req_valid) begin
               ctl.op   = OP_LATCH;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.cmd)
               CMD_RECORD:  state_in = S_REC_RD;
               CMD_READ: begin
                  if (sts.in_range) begin
                     ctl.op   = OP_RD_IDX;
                     state_in = S_READ_WAIT;
                  end else begin
                     ctl.op   = OP_MISS;
                     state_in = S_FINISH;
                  end
               end
               CMD_BUSIEST: state_in = S_BUS_RD;
               CMD_SORT: begin
                  ctl.op   = OP_SORT_INIT;
                  state_in = S_SORT_I;
               end
               CMD_TALLY:   state_in = S_TAL_RD;
               default: begin
                  ctl.op   = OP_MISS;
                  state_in = S_FINISH;
               end
            endcase
         end
         S_REC_RD: begin
            if (sts.at_end) begin
               state_in = S_REC_NEW;
            end else begin
               ctl.op   = OP_RD_PTR;
               state_in = S_REC_CHK;
            end
         end
         S_REC_CHK: begin
            if (sts.hit) begin
               ctl.op   = OP_REC_HIT;
               state_in = S_FINISH;
            end else begin
               ctl.op   = OP_PTR_INC;
               state_in = S_REC_RD;
            end
         end
         S_REC_NEW: begin
            ctl.op   = sts.full ? OP_REC_DROP : OP_REC_NEW;
            state_in = S_FINISH;
         end
         S_READ_WAIT: begin
            ctl.op   = OP_READ_DONE;
            state_in = S_FINISH;
         end
         S_BUS_RD: begin
            if (sts.at_end) begin
               ctl.op   = OP_BUS_DONE;
               state_in = S_FINISH;
            end else begin
               ctl.op   = OP_RD_PTR;
               state_in = S_BUS_CHK;
            end
         end
         S_BUS_CHK: begin
            ctl.op   = OP_BUS_STEP;
            state_in = S_BUS_RD;
         end
         S_TAL_RD: begin
            if (sts.at_end) begin
               ctl.op   = OP_TAL_DONE;
               state_in = S_FINISH;
            end else begin
               ctl.op   = OP_RD_PTR;
               state_in = S_TAL_CHK;
            end
         end
         S_TAL_CHK: begin
            ctl.op   = OP_TAL_STEP;
            state_in = S_TAL_RD;
         end
         S_SORT_I: begin
            if (sts.at_end) begin
               ctl.op   = OP_SORT_DONE;
               state_in = S_FINISH;
            end else begin
               ctl.op   = OP_RD_PTR;
               state_in = S_SORT_KEY;
            end
         end
         S_SORT_KEY: begin
            ctl.op   = OP_SORT_KEY;
            state_in = S_SORT_J;
         end
         S_SORT_J: begin
            if (sts.j_zero) begin
               ctl.op   = OP_SORT_PLACE;
               state_in = S_SORT_I;
            end else begin
               ctl.op   = OP_RD_JM1;
               state_in = S_SORT_CMP;
            end
         end
         S_SORT_CMP: begin
            if (sts.ahead) begin
               ctl.op   = OP_SORT_SHIFT;
               state_in = S_SORT_J;
            end else begin
               ctl.op   = OP_SORT_PLACE;
               state_in = S_SORT_I;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               ctl.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

[rtl/cat_dpath.sv]
// cat_dpath: table RAM, counters, scan/sort registers, config and output word.
// Depends on cat_pkg, cat_if and cat_ram; commanded by cat_ctrl.
module cat_dpath import cat_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_type               ctl,
   output sts_type               sts,
   cat_req_if.sink               req_chan,
   cat_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   cfg_type            cfg_ff, cfg_in;
   logic [CNT_W-1:0]   count_ff, count_in, ptr_ff, ptr_in, j_ff, j_in, jm1;
   logic [15:0]        drop_ff, drop_in, total_ff, total_in;
   logic               valid_ff, valid_in;
   cmd_type            cmd_ff, cmd_in;
   logic [20:0]        cap_ff, cap_in;
   logic [1:0]         kind_ff, kind_in;
   logic [15:0]        fl_ff, fl_in;
   logic [7:0]         sc_ff, sc_in;
   logic [3:0]         gr_ff, gr_in;
   logic [31:0]        tick_ff, tick_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   row_type            acc_ff, acc_in;
   res_type            res_ff, res_in, out_ff, out_in;
   logic [5:0]         occ_ff, occ_in;
   logic [15:0]        ovf_ff, ovf_in;

   logic               rd_en, wr_en;
   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   row_type            wr_data, rd_row, new_row, upd_hit, upd_new;
   logic               ptr_zero;

   cat_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_row)
   );

   assign jm1      = j_ff - CNT_W'(1);
   assign ptr_zero = (ptr_ff == '0);

   always_comb begin
      new_row            = '0;
      new_row.key        = cap_ff;
      new_row.first_tick = tick_ff;
   end

   assign upd_hit = rec_update(rd_row, fl_ff, kind_ff, sc_ff, gr_ff, tick_ff, cfg_ff);
   assign upd_new = rec_update(new_row, fl_ff, kind_ff, sc_ff, gr_ff, tick_ff, cfg_ff);

   always_comb begin
      sts.cmd       = cmd_ff;
      sts.req_valid = req_chan.valid;
      sts.at_end    = (ptr_ff >= count_ff);
      sts.hit       = (rd_row.key == cap_ff);
      sts.full      = (count_ff == CNT_W'(TABLE_DEPTH));
      sts.j_zero    = (j_ff == '0);
      // stable insertion: key moves ahead only on strictly greater
      sts.ahead     = (acc_ff.pages > rd_row.pages) ||
                      (acc_ff.pages == rd_row.pages && acc_ff.score > rd_row.score);
      sts.in_range  = (WIDE_W'(idx_ff) < WIDE_W'(count_ff));
      sts.out_free  = !valid_ff || rsp_chan.ready;
   end

   always_comb begin
      cfg_in   = cfg_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      j_in     = j_ff;
      drop_in  = drop_ff;
      total_in = total_ff;
      cmd_in   = cmd_ff;
      cap_in   = cap_ff;
      kind_in  = kind_ff;
      fl_in    = fl_ff;
      sc_in    = sc_ff;
      gr_in    = gr_ff;
      tick_in  = tick_ff;
      idx_in   = idx_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      out_in   = out_ff;
      occ_in   = occ_ff;
      ovf_in   = ovf_ff;
      valid_in = valid_ff;
      rd_en    = 1'b0;
      rd_addr  = ptr_ff[ADDR_W-1:0];
      wr_en    = 1'b0;
      wr_addr  = ptr_ff[ADDR_W-1:0];
      wr_data  = rd_row;

      if (csr_we) begin
         case (csr_index)
            CSR_IDENTITY: cfg_in.identity_mask = csr_wdata;
            CSR_LOCATION: cfg_in.location_mask = csr_wdata;
            CSR_CLINICAL: cfg_in.clinical_mask = csr_wdata;
            CSR_INCIDENT: cfg_in.incident_mask = csr_wdata;
            CSR_TONE:     cfg_in.tone_kind     = csr_wdata[1:0];
            CSR_NUMERIC:  cfg_in.numeric_kind  = csr_wdata[1:0];
            default: ;
         endcase
      end

      case (ctl.op)
         OP_LATCH: begin
            cmd_in  = req_chan.cmd;
            cap_in  = req_chan.capcode;
            kind_in = req_chan.page_kind;
            fl_in   = req_chan.leak_flags;
            sc_in   = req_chan.score;
            gr_in   = req_chan.grade;
            tick_in = req_chan.tick_ms;
            idx_in  = req_chan.index;
            ptr_in  = '0;
            acc_in  = '0;
            if (req_chan.cmd == CMD_RECORD && total_ff != SAT16) begin
               total_in = total_ff + 16'd1;
            end
         end
         OP_RD_PTR:  rd_en = 1'b1;
         OP_PTR_INC: ptr_in = ptr_ff + CNT_W'(1);
         OP_REC_HIT: begin
            wr_en   = 1'b1;
            wr_data = upd_hit;
            res_in  = '{status: ST_OK, row: upd_hit};
         end
         OP_REC_NEW: begin
            wr_en    = 1'b1;
            wr_addr  = count_ff[ADDR_W-1:0];
            wr_data  = upd_new;
            count_in = count_ff + CNT_W'(1);
            res_in   = '{status: ST_OK, row: upd_new};
         end
         OP_REC_DROP: begin
            if (drop_ff != SAT16) drop_in = drop_ff + 16'd1;
            res_in = '{status: ST_FULL, row: '0};
         end
         OP_RD_IDX: begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(idx_ff);
         end
         OP_READ_DONE: res_in = '{status: ST_OK, row: rd_row};
         OP_MISS:      res_in = '{status: ST_MISS, row: '0};
         OP_BUS_STEP: begin
            if (ptr_zero || rd_row.pages > acc_ff.pages) acc_in = rd_row;
            ptr_in = ptr_ff + CNT_W'(1);
         end
         OP_BUS_DONE: begin
            if (count_ff == '0) res_in = '{status: ST_MISS, row: '0};
            else                res_in = '{status: ST_OK, row: acc_ff};
         end
         OP_TAL_STEP: begin
            acc_in.flags           = acc_ff.flags | rd_row.flags;
            acc_in.category[15:0]  = acc_ff.category[15:0] + {8'd0, rd_row.category[23:16]};
            acc_in.category[31:16] = acc_ff.category[31:16] + {8'd0, rd_row.category[31:24]};
            if (rd_row.score > acc_ff.score) begin
               acc_in.score = rd_row.score;
               acc_in.grade = rd_row.grade;
            end
            if (ptr_zero || rd_row.first_tick < acc_ff.first_tick) begin
               acc_in.first_tick = rd_row.first_tick;
            end
            if (ptr_zero || rd_row.last_tick > acc_ff.last_tick) begin
               acc_in.last_tick = rd_row.last_tick;
            end
            ptr_in = ptr_ff + CNT_W'(1);
         end
         OP_TAL_DONE: begin
            res_in.status    = ST_OK;
            res_in.row       = acc_ff;
            res_in.row.pages = total_ff;
         end
         OP_SORT_INIT: ptr_in = CNT_W'(1);
         OP_SORT_KEY: begin
            acc_in = rd_row;
            j_in   = ptr_ff;
         end
         OP_RD_JM1: begin
            rd_en   = 1'b1;
            rd_addr = jm1[ADDR_W-1:0];
         end
         OP_SORT_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[ADDR_W-1:0];
            wr_data = rd_row;
            j_in    = jm1;
         end
         OP_SORT_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[ADDR_W-1:0];
            wr_data = acc_ff;
            ptr_in  = ptr_ff + CNT_W'(1);
         end
         OP_SORT_DONE: res_in = '{status: ST_OK, row: '0};
         default: ;
      endcase

      // output word register frees the sequencer while a result waits
      if (ctl.rsp_load) begin
         out_in   = res_ff;
         occ_in   = 6'(count_ff);
         ovf_in   = drop_ff;
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= '{identity_mask: 16'd60, location_mask: 16'd448,
                       clinical_mask: 16'd1, incident_mask: 16'd2,
                       tone_kind: 2'd0, numeric_kind: 2'd1};
         count_ff <= '0;
         ptr_ff   <= '0;
         drop_ff  <= '0;
         total_ff <= '0;
         valid_ff <= 1'b0;
         out_ff   <= '0;
         occ_ff   <= '0;
         ovf_ff   <= '0;
      end else begin
         cfg_ff   <= cfg_in;
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
         drop_ff  <= drop_in;
         total_ff <= total_in;
         valid_ff <= valid_in;
         out_ff   <= out_in;
         occ_ff   <= occ_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff    <= j_in;
      cmd_ff  <= cmd_in;
      cap_ff  <= cap_in;
      kind_ff <= kind_in;
      fl_ff   <= fl_in;
      sc_ff   <= sc_in;
      gr_ff   <= gr_in;
      tick_ff <= tick_in;
      idx_ff  <= idx_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
   end

   assign req_chan.ready           = ctl.req_ready;
   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.status          = out_ff.status;
   assign rsp_chan.entry_capcode   = out_ff.row.key;
   assign rsp_chan.page_total      = out_ff.row.pages;
   assign rsp_chan.first_seen      = out_ff.row.first_tick;
   assign rsp_chan.last_seen       = out_ff.row.last_tick;
   assign rsp_chan.flags_seen      = out_ff.row.flags;
   assign rsp_chan.worst_score_out = out_ff.row.score;
   assign rsp_chan.worst_grade_out = out_ff.row.grade;
   assign rsp_chan.category_counts = out_ff.row.category;
   assign rsp_chan.role            = out_ff.row.role;
   assign rsp_chan.occupancy       = occ_ff;
   assign rsp_chan.overflow_count  = ovf_ff;
endmodule

[rtl/capcode_activity_table.sv]
// Capcode activity table: per-capcode paging statistics in a 32-row RAM with one
// write and one registered read port, one request word at a time. Each RAM read is
// issued and its data then registered, so timing follows the stored row count n:
// record scans until it finds the capcode, busiest and tally scan all n rows, read
// fetches a single row, and sort is a stable insertion sort through the same ports.
// The table starts empty with no clearing pass. A result sits in an output
// register, so the next request is taken while the previous word waits. Config
// writes are expected only while idle.
module capcode_activity_table import cat_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   cat_req_if.sink               req_chan,
   cat_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   ctl_type ctl;
   sts_type sts;

   cat_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .sts  (sts),
      .ctl  (ctl)
   );

   cat_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .sts      (sts),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );
endmodule

[rtl/cat_checker.sv]
// cat_checker: port-level assertions for the capcode activity table, bound to
// the top level. Depends on cat_pkg.
module cat_checker import cat_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  status,
   input logic [5:0]  occupancy,
   input logic [15:0] overflow_count
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped before taken");

   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_FULL |-> occupancy == 6'(TABLE_DEPTH))
      else $error("full status with table not full");

   a_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> occupancy >= $past(occupancy) &&
                        overflow_count >= $past(overflow_count))
      else $error("occupancy or overflow count went down");
endmodule

bind capcode_activity_table cat_checker u_cat_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .status        (rsp_chan.status),
   .occupancy     (rsp_chan.occupancy),
   .overflow_count(rsp_chan.overflow_count)
);
